/* rtl/hpss_pkg.sv */
package hpss_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_RHO_COUNT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THETA_COUNT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_THETA_RADIUS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RHO_RADIUS   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_TOTAL   = 3'd6;

	// Peak rounds per loaded matrix are limited to this count.
	localparam int PEAK_LIMIT = 64;
	localparam int ROUND_W    = $clog2(PEAK_LIMIT);

	// Widths of the result fields.
	localparam int PEAK_VALUE_W = 16;
	localparam int INDEX_W      = 8;

	typedef struct packed {
		logic [8:0] rho_count;
		logic [8:0] theta_count;
		logic [8:0] window_start;
		logic [8:0] window_end;
		logic [7:0] theta_radius;
		logic [7:0] rho_radius;
		logic [6:0] peak_total;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rho_count:    9'd256,
		theta_count:  9'd256,
		window_start: 9'd0,
		window_end:   9'd256,
		theta_radius: 8'd1,
		rho_radius:   8'd2,
		peak_total:   7'd8
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_write;
		logic start;
		logic round_init;
		logic seg_next;
		logic mul_seg;
		logic mul_sup;
		logic scan_init;
		logic scan_step;
		logic emit;
		logic sup_init;
		logic sup_step;
		logic round_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seg_empty;
		logic seg_more;
		logic scan_last;
		logic sup_last;
		logic round_last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/hpss_ctrl.sv */
module hpss_ctrl import hpss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_vote,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_LOAD    = 4'd0;
	localparam logic [3:0] S_ROUND   = 4'd1;
	localparam logic [3:0] S_SEGCHK  = 4'd2;
	localparam logic [3:0] S_SCINIT  = 4'd3;
	localparam logic [3:0] S_SCAN    = 4'd4;
	localparam logic [3:0] S_DRAIN   = 4'd5;
	localparam logic [3:0] S_EMIT    = 4'd6;
	localparam logic [3:0] S_SUPMUL  = 4'd7;
	localparam logic [3:0] S_SUPINIT = 4'd8;
	localparam logic [3:0] S_SUP     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// Vote words are taken only while loading.
	assign in_ready = (state_q == S_LOAD);

	// Sequencing of load, search, report and suppression.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load_write = in_valid;
				if (in_valid && last_vote) begin
					cmd.start = 1'b1;
					state_nxt = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round_init = 1'b1;
				state_nxt      = S_SEGCHK;
			end
			S_SEGCHK: begin
				if (sts.seg_empty) begin
					if (sts.seg_more) begin
						cmd.seg_next = 1'b1;
					end else begin
						state_nxt = S_DRAIN;
					end
				end else begin
					cmd.mul_seg = 1'b1;
					state_nxt   = S_SCINIT;
				end
			end
			S_SCINIT: begin
				cmd.scan_init = 1'b1;
				state_nxt     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					if (sts.seg_more) begin
						cmd.seg_next = 1'b1;
						state_nxt    = S_SEGCHK;
					end else begin
						state_nxt = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_SUPMUL;
				end
			end
			S_SUPMUL: begin
				cmd.mul_sup = 1'b1;
				state_nxt   = S_SUPINIT;
			end
			S_SUPINIT: begin
				cmd.sup_init = 1'b1;
				state_nxt    = S_SUP;
			end
			S_SUP: begin
				cmd.sup_step = 1'b1;
				if (sts.sup_last) begin
					if (sts.round_last) begin
						state_nxt = S_LOAD;
					end else begin
						cmd.round_inc = 1'b1;
						state_nxt     = S_ROUND;
					end
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* rtl/hpss_dp.sv */
module hpss_dp import hpss_pkg::*; #(
	parameter int MAX_RHO_BINS   = 256,
	parameter int MAX_THETA_BINS = 256,
	parameter int VOTE_WIDTH     = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [15:0]             vote_count,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [PEAK_VALUE_W-1:0] peak_value,
	output logic [INDEX_W-1:0]      theta_index,
	output logic [INDEX_W-1:0]      rho_index,
	output logic                    last_peak
);

	localparam int DEPTH = MAX_RHO_BINS * MAX_THETA_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (VOTE_WIDTH < 16) ? VOTE_WIDTH : 16;
	localparam int RCW   = $clog2(MAX_RHO_BINS + 1);
	localparam int CCW   = $clog2(MAX_THETA_BINS + 1);
	// Row and column arithmetic room for a register value plus a radius.
	localparam int RXW   = ((RCW > 9) ? RCW : 9) + 1;
	localparam int CXW   = ((CCW > 9) ? CCW : 9) + 1;
	localparam int MW    = RXW + CXW;

	localparam logic [RXW-1:0] MAX_ROWS = RXW'(MAX_RHO_BINS);
	localparam logic [CXW-1:0] MAX_COLS = CXW'(MAX_THETA_BINS);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [6:0]     TOTAL_MAX = 7'(PEAK_LIMIT);

	// Clamped configuration.
	logic [RXW-1:0] rho_x, m_x, rr_x;
	logic [CXW-1:0] theta_x, n_x, tr_x, ws_x, we_x, endc;
	logic           wrapped;
	logic [6:0]     total;

	assign rho_x   = RXW'(cfg.rho_count);
	assign theta_x = CXW'(cfg.theta_count);
	assign m_x     = (rho_x == '0) ? RXW'(1) : ((rho_x > MAX_ROWS) ? MAX_ROWS : rho_x);
	assign n_x     = (theta_x == '0) ? CXW'(1) : ((theta_x > MAX_COLS) ? MAX_COLS : theta_x);
	assign rr_x    = RXW'(cfg.rho_radius);
	assign tr_x    = CXW'(cfg.theta_radius);
	assign ws_x    = CXW'(cfg.window_start);
	assign we_x    = CXW'(cfg.window_end);
	assign wrapped = (cfg.window_end < cfg.window_start);
	assign endc    = (we_x < n_x) ? we_x : n_x;
	assign total   = (cfg.peak_total == '0) ? 7'd1 :
		((cfg.peak_total > TOTAL_MAX) ? TOTAL_MAX : cfg.peak_total);

	// Vote store and its registered read port.
	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;

	// Control registers.
	logic [AW-1:0]      ptr_q;
	logic               seg_q;
	logic               vld_s1;
	logic [ROUND_W-1:0] round_q;
	logic               out_valid_q;

	// Walk and search registers.
	logic [AW-1:0]  addr_q, base_q, prod_q;
	logic [CXW-1:0] col_q, col_s1, best_col_q;
	logic [RXW-1:0] row_q, row_s1, best_row_q;
	logic [SW-1:0]  best_val_q;
	logic [CXW-1:0] j0_q, j1_q;
	logic [RXW-1:0] i0_q, i1_q;

	// Result register.
	logic [SW-1:0]      pv_q;
	logic [INDEX_W-1:0] ti_q, ri_q;
	logic               lp_q;

	// Current scan segment; a wrapped window has two.
	logic [CXW-1:0] seg_from, seg_to;

	assign seg_from = (wrapped && !seg_q) ? '0 : ws_x;
	assign seg_to   = (wrapped && seg_q) ? n_x : endc;

	// Suppression rectangle around the current best, clamped to the matrix.
	logic [CXW-1:0] jsum, j0_d, j1_d;
	logic [RXW-1:0] isum, i0_d, i1_d;

	assign jsum = best_col_q + tr_x;
	assign isum = best_row_q + rr_x;
	assign j0_d = (best_col_q > tr_x) ? (best_col_q - tr_x) : '0;
	assign j1_d = (jsum < (n_x - CXW'(1))) ? jsum : (n_x - CXW'(1));
	assign i0_d = (best_row_q > rr_x) ? (best_row_q - rr_x) : '0;
	assign i1_d = (isum < (m_x - RXW'(1))) ? isum : (m_x - RXW'(1));

	// Column start address: one multiply, registered.
	logic [CXW-1:0] mul_a;
	logic [MW-1:0]  prod_full;

	assign mul_a     = cmd.mul_sup ? j0_q : seg_from;
	assign prod_full = MW'(mul_a) * MW'(m_x);

	// Status to the controller.
	assign sts.seg_empty  = (seg_from >= seg_to);
	assign sts.seg_more   = wrapped && !seg_q;
	assign sts.scan_last  = (row_q == (m_x - RXW'(1))) && (col_q == (seg_to - CXW'(1)));
	assign sts.sup_last   = (row_q == i1_q) && (col_q == j1_q);
	assign sts.round_last = ({1'b0, round_q} == (total - 7'd1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Loading writes vote words; suppression writes zeros.
	assign mem_we    = cmd.load_write || cmd.sup_step;
	assign mem_waddr = cmd.sup_step ? addr_q : ptr_q;
	assign mem_wdata = cmd.sup_step ? '0 : SW'(vote_count);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[addr_q];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			seg_q       <= 1'b0;
			vld_s1      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (cmd.load_write) begin
				ptr_q <= (ptr_q == LAST_ADDR) ? '0 : (ptr_q + AW'(1));
			end

			if (cmd.round_init) begin
				seg_q <= 1'b0;
			end else if (cmd.seg_next) begin
				seg_q <= 1'b1;
			end

			vld_s1 <= cmd.scan_step;

			if (cmd.start) begin
				round_q <= '0;
			end else if (cmd.round_inc) begin
				round_q <= round_q + ROUND_W'(1);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Address walk over the scan window and the suppression rectangle.
	always_ff @(posedge clk) begin
		if (cmd.mul_seg || cmd.mul_sup) begin
			prod_q <= prod_full[AW-1:0];
		end

		if (cmd.scan_init) begin
			addr_q <= prod_q;
			col_q  <= seg_from;
			row_q  <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + AW'(1);
			if (row_q == (m_x - RXW'(1))) begin
				row_q <= '0;
				col_q <= col_q + CXW'(1);
			end else begin
				row_q <= row_q + RXW'(1);
			end
		end else if (cmd.sup_init) begin
			base_q <= prod_q;
			addr_q <= prod_q + AW'(i0_q);
			col_q  <= j0_q;
			row_q  <= i0_q;
		end else if (cmd.sup_step) begin
			if (row_q == i1_q) begin
				row_q  <= i0_q;
				col_q  <= col_q + CXW'(1);
				base_q <= base_q + AW'(m_x);
				addr_q <= base_q + AW'(m_x) + AW'(i0_q);
			end else begin
				row_q  <= row_q + RXW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end

		col_s1 <= col_q;
		row_s1 <= row_q;
	end

	// Running maximum: the first strictly larger vote wins.
	always_ff @(posedge clk) begin
		if (cmd.round_init) begin
			best_val_q <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
		end else if (vld_s1 && (rdata_q > best_val_q)) begin
			best_val_q <= rdata_q;
			best_col_q <= col_s1;
			best_row_q <= row_s1;
		end
	end

	// Result beat and the suppression bounds for this round.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pv_q <= best_val_q;
			ti_q <= best_col_q[INDEX_W-1:0];
			ri_q <= best_row_q[INDEX_W-1:0];
			lp_q <= sts.round_last;
			j0_q <= j0_d;
			j1_q <= j1_d;
			i0_q <= i0_d;
			i1_q <= i1_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_value  = PEAK_VALUE_W'(pv_q);
	assign theta_index = ti_q;
	assign rho_index   = ri_q;
	assign last_peak   = lp_q;

endmodule

/* rtl/hough_peak_search_suppress.sv */
// Hough peak search with non-maximum suppression.
//
// Input channel (in_valid/in_ready): one vote word per beat, column-major with
// rho fastest. While loading, in_ready stays high and a beat is taken every
// cycle. The beat with last_vote set is stored and starts the search; in_ready
// then stays low until the final round has finished its suppression.
// Output channel (out_valid/out_ready): one result beat per round, peak_total
// rounds (0 taken as 1, capped at PEAK_LIMIT), the final one flagged with
// last_peak. Each round scans the theta window through the single read port
// of the vote store, one word per cycle, then zeroes the suppression
// rectangle through the write port, one word per cycle.
// One result register sits on the output; a stalled receiver holds the search
// in the report step of the next round until that register frees up.
// Reset returns the configuration registers to their defaults and the load
// pointer to zero; the vote store holds no defined contents until loaded.
// Configuration writes belong in idle time, since the search reads the
// registers directly.
module hough_peak_search_suppress import hpss_pkg::*; #(
	parameter int MAX_RHO_BINS   = 256,
	parameter int MAX_THETA_BINS = 256,
	parameter int VOTE_WIDTH     = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             vote_count,
	input  logic                    last_vote,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PEAK_VALUE_W-1:0] peak_value,
	output logic [INDEX_W-1:0]      theta_index,
	output logic [INDEX_W-1:0]      rho_index,
	output logic                    last_peak
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Configuration register file; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RHO_COUNT:    cfg_q.rho_count    <= cfg_data;
				REG_THETA_COUNT:  cfg_q.theta_count  <= cfg_data;
				REG_WINDOW_START: cfg_q.window_start <= cfg_data;
				REG_WINDOW_END:   cfg_q.window_end   <= cfg_data;
				REG_THETA_RADIUS: cfg_q.theta_radius <= cfg_data[7:0];
				REG_RHO_RADIUS:   cfg_q.rho_radius   <= cfg_data[7:0];
				REG_PEAK_TOTAL:   cfg_q.peak_total   <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	hpss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_vote (last_vote),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpss_dp #(
		.MAX_RHO_BINS   (MAX_RHO_BINS),
		.MAX_THETA_BINS (MAX_THETA_BINS),
		.VOTE_WIDTH     (VOTE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.vote_count  (vote_count),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.peak_value  (peak_value),
		.theta_index (theta_index),
		.rho_index   (rho_index),
		.last_peak   (last_peak)
	);

endmodule

/* rtl/hpss_checker.sv */
module hpss_checker import hpss_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    last_vote,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [PEAK_VALUE_W-1:0] peak_value,
	input logic [INDEX_W-1:0]      theta_index,
	input logic [INDEX_W-1:0]      rho_index,
	input logic                    last_peak
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(peak_value) && $stable(theta_index)
			&& $stable(rho_index) && $stable(last_peak))
		else $error("result payload changed while stalled");

	// The final vote word closes the input until the run is over.
	a_load_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_vote |=> !in_ready)
		else $error("input open right after the final vote word");

	// While a peak other than the final one is pending, loading stays closed.
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_peak |-> !in_ready)
		else $error("input open in the middle of a peak run");

endmodule

bind hough_peak_search_suppress hpss_checker u_hpss_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import hpss_pkg::*;

	localparam int unsigned MAX_RHO     = 256;
	localparam int unsigned MAX_THETA   = 256;
	localparam int unsigned STORE_DEPTH = MAX_RHO * MAX_THETA;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned RANDOM_VOTES = 180;
	localparam int unsigned EFF_CAP     = 48;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0] value;
		logic [7:0]  theta;
		logic [7:0]  rho;
		logic        last;
	} peak_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [15:0]             vote_count = '0;
	logic                    last_vote = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [PEAK_VALUE_W-1:0] peak_value;
	logic [INDEX_W-1:0]      theta_index;
	logic [INDEX_W-1:0]      rho_index;
	logic                    last_peak;

	// Shadow of the block: vote store, load pointer and registers.
	logic [15:0]  vote_mem [0:STORE_DEPTH-1];
	int unsigned  load_ptr = 0;
	int unsigned  store_fill = 0;
	cfg_t         shadow_cfg = CFG_RESET;
	int unsigned  best_value, best_theta, best_rho;
	peak_t        pending_peaks[$];

	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  ready_hold = 0;
	int unsigned  ready_roll;
	bit           tx_calm = 1'b0;
	bit           rx_calm = 1'b0;
	peak_t        head_peak;

	hough_peak_search_suppress DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vote_count  (vote_count),
		.last_vote   (last_vote),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_value  (peak_value),
		.theta_index (theta_index),
		.rho_index   (rho_index),
		.last_peak   (last_peak)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned limit_to(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Walk columns [from_col, to_col), rows ascending, keeping the first strict maximum.
	task automatic scan_theta_range(input int unsigned from_col, input int unsigned to_col,
			input int unsigned rows);
		for (int unsigned j = from_col; j < to_col; j++) begin
			for (int unsigned i = 0; i < rows; i++) begin
				if (32'(vote_mem[j * rows + i]) > best_value) begin
					best_value = 32'(vote_mem[j * rows + i]);
					best_theta = j;
					best_rho   = i;
				end
			end
		end
	endtask

	// Store one accepted vote beat; a last beat runs every peak round and queues the peaks.
	task automatic apply_vote(input logic [15:0] vote, input logic last);
		int unsigned rows, cols, rounds, end_col, ws, we;
		int unsigned tr, rr, j_lo, j_hi, i_lo, i_hi;
		peak_t pk;
		vote_mem[load_ptr] = vote;
		load_ptr++;
		if (load_ptr > store_fill) store_fill = load_ptr;
		if (load_ptr >= STORE_DEPTH) load_ptr = 0;
		if (!last) return;
		load_ptr = 0;
		rows    = limit_to(32'(shadow_cfg.rho_count), 1, MAX_RHO);
		cols    = limit_to(32'(shadow_cfg.theta_count), 1, MAX_THETA);
		rounds  = limit_to(32'(shadow_cfg.peak_total), 1, PEAK_LIMIT);
		ws      = 32'(shadow_cfg.window_start);
		we      = 32'(shadow_cfg.window_end);
		end_col = (we < cols) ? we : cols;
		tr      = 32'(shadow_cfg.theta_radius);
		rr      = 32'(shadow_cfg.rho_radius);
		for (int unsigned k = 0; k < rounds; k++) begin
			best_value = 0;
			best_theta = 0;
			best_rho   = 0;
			if (we < ws) begin
				scan_theta_range(0, end_col, rows);
				scan_theta_range(ws, cols, rows);
			end else begin
				scan_theta_range(ws, end_col, rows);
			end
			pk.value = best_value[15:0];
			pk.theta = best_theta[7:0];
			pk.rho   = best_rho[7:0];
			pk.last  = (k + 1 == rounds);
			pending_peaks.push_back(pk);
			// Zero the rectangle around the peak, clamped to the matrix.
			j_lo = (best_theta > tr) ? best_theta - tr : 0;
			j_hi = (best_theta + tr < cols - 1) ? best_theta + tr : cols - 1;
			i_lo = (best_rho > rr) ? best_rho - rr : 0;
			i_hi = (best_rho + rr < rows - 1) ? best_rho + rr : rows - 1;
			for (int unsigned j = j_lo; j <= j_hi; j++)
				for (int unsigned i = i_lo; i <= i_hi; i++)
					vote_mem[j * rows + i] = '0;
		end
	endtask

	// Cycles the block may still spend suppressing after its final peak beat.
	function automatic int unsigned settle_cycles();
		int unsigned rows, cols, span_c, span_r;
		rows   = limit_to(32'(shadow_cfg.rho_count), 1, MAX_RHO);
		cols   = limit_to(32'(shadow_cfg.theta_count), 1, MAX_THETA);
		span_c = 2 * 32'(shadow_cfg.theta_radius) + 1;
		span_r = 2 * 32'(shadow_cfg.rho_radius) + 1;
		if (span_c > cols) span_c = cols;
		if (span_r > rows) span_r = rows;
		return span_c * span_r + 32;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] random_vote(input int unsigned flavor);
		int unsigned r;
		if (flavor == 0) return 16'($urandom);
		if (flavor == 1) return 16'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		if (r < 3) return 16'h0000;
		if (r < 5) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
	endtask

	// Send one vote beat and hold it until the block takes it.
	task automatic send_vote(input logic [15:0] vote, input logic last);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		vote_count <= vote;
		last_vote  <= last;
		do @(posedge clk); while (!in_ready);
		apply_vote(vote, last);
	endtask

	// Stop sending, let every queued peak arrive, then let suppression finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_peaks.size() != 0) @(posedge clk);
		repeat (settle_cycles()) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_RHO_COUNT:    shadow_cfg.rho_count    = value[8:0];
			REG_THETA_COUNT:  shadow_cfg.theta_count  = value[8:0];
			REG_WINDOW_START: shadow_cfg.window_start = value[8:0];
			REG_WINDOW_END:   shadow_cfg.window_end   = value[8:0];
			REG_THETA_RADIUS: shadow_cfg.theta_radius = value[7:0];
			REG_RHO_RADIUS:   shadow_cfg.rho_radius   = value[7:0];
			REG_PEAK_TOTAL:   shadow_cfg.peak_total   = value[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input int unsigned rows, input int unsigned cols,
			input int unsigned ws, input int unsigned we, input int unsigned tr,
			input int unsigned rr, input int unsigned pt);
		wait_idle();
		write_reg(REG_RHO_COUNT, rows);
		write_reg(REG_THETA_COUNT, cols);
		write_reg(REG_WINDOW_START, ws);
		write_reg(REG_WINDOW_END, we);
		write_reg(REG_THETA_RADIUS, tr);
		write_reg(REG_RHO_RADIUS, rr);
		write_reg(REG_PEAK_TOTAL, pt);
	endtask

	task automatic load_matrix(input int unsigned words, input int unsigned flavor);
		for (int unsigned w = 0; w < words; w++)
			send_vote(random_vote(flavor), w == words - 1);
	endtask

	// Extreme votes, equal votes (first one wins) and a fully suppressed matrix.
	task automatic test_ties_and_extremes();
		logic [15:0] seq [6];
		seq = '{16'd5, 16'd9, 16'd9, 16'hFFFF, 16'd0, 16'hFFFF};
		program_regs(2, 3, 0, 3, 0, 0, 6);
		for (int unsigned w = 0; w < 6; w++) send_vote(seq[w], w == 5);
	endtask

	// Wrapped, empty and out-of-range search windows.
	task automatic test_window_modes();
		int unsigned starts [4];
		int unsigned ends [4];
		starts = '{1, 1, 300, 511};
		ends   = '{0, 1, 400, 1};
		for (int unsigned s = 0; s < 4; s++) begin
			program_regs(1, 2, starts[s], ends[s], 0, 0, 2);
			load_matrix(2, 2);
		end
	endtask

	// Suppression clamped at the matrix edges, zero counts and a peak count past the limit.
	task automatic test_clamps();
		program_regs(3, 3, 0, 256, 255, 255, 2);
		load_matrix(9, 0);
		program_regs(0, 0, 0, 256, 1, 2, 0);
		load_matrix(1, 0);
		program_regs(2, 2, 0, 256, 0, 0, 127);
		load_matrix(1, 1);
	endtask

	task automatic test_unknown_register();
		wait_idle();
		write_reg(REG_UNUSED, 9'h1FF);
		load_matrix(1, 0);
	endtask

	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 8);
		if (r < 93) return $urandom_range(9, 24);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 256;
			2: return 511;
			default: return $urandom_range(25, 256);
		endcase
	endfunction

	function automatic int unsigned pick_radius();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 90) return $urandom_range(3, 8);
		return 255;
	endfunction

	// Random geometry, windows and radii; mostly complete matrices, some short or long.
	// A short matrix is sent only when earlier loads already cover the whole matrix.
	task automatic test_random_matrices();
		int unsigned rows, cols, cols_eff, eff, ws, we, tr, rr, pt, r, words, sent;
		sent = 0;
		while (sent < RANDOM_VOTES) begin
			rows = pick_count();
			cols = pick_count();
			if (limit_to(rows, 1, MAX_RHO) * limit_to(cols, 1, MAX_THETA) > EFF_CAP) begin
				rows = $urandom_range(1, 12);
				cols = $urandom_range(1, 4);
			end
			cols_eff = limit_to(cols, 1, MAX_THETA);
			eff = limit_to(rows, 1, MAX_RHO) * cols_eff;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				ws = 0;
				we = (r < 15) ? 256 : cols_eff;
			end else if (r < 65) begin
				ws = $urandom_range(0, cols_eff);
				we = $urandom_range(ws, cols_eff + 1);
			end else if (r < 92) begin
				we = $urandom_range(0, cols_eff);
				ws = $urandom_range(we + 1, cols_eff + 1);
			end else begin
				ws = $urandom_range(0, 511);
				we = $urandom_range(0, 511);
			end
			tr = pick_radius();
			rr = pick_radius();
			r = $urandom_range(0, 99);
			if (r < 80) pt = $urandom_range(1, 6);
			else if (r < 95) pt = $urandom_range(7, 64);
			else begin
				case ($urandom_range(0, 2))
					0: pt = 0;
					1: pt = 64;
					default: pt = 127;
				endcase
			end
			program_regs(rows, cols, ws, we, tr, rr, pt);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 75) words = eff;
			else if (r < 90) words = (store_fill >= eff) ? $urandom_range(1, eff) : eff;
			else words = eff + $urandom_range(1, 4);
			load_matrix(words, $urandom_range(0, 2));
			sent += words;
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Receiver readiness: mostly ready, with short and occasional long stalls.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (rx_calm || ready_roll < 65) begin
				out_ready  <= 1'b1;
				ready_hold <= $urandom_range(0, 6);
			end else if (ready_roll < 92) begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(8, 40);
			end
		end
	end

	// Compare each peak beat against the oldest queued peak.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_peaks.size() == 0) begin
				report_mismatch("peak with none pending", 32'(peak_value), 0);
			end else begin
				head_peak = pending_peaks.pop_front();
				if (peak_value !== head_peak.value)
					report_mismatch("peak_value", 32'(peak_value), 32'(head_peak.value));
				if (theta_index !== head_peak.theta)
					report_mismatch("theta_index", 32'(theta_index), 32'(head_peak.theta));
				if (rho_index !== head_peak.rho)
					report_mismatch("rho_index", 32'(rho_index), 32'(head_peak.rho));
				if (last_peak !== head_peak.last)
					report_mismatch("last_peak", 32'(last_peak), 32'(head_peak.last));
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ties_and_extremes();
		test_window_modes();
		test_clamps();
		test_unknown_register();
		test_random_matrices();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
